### sv/mwcs_pkg.sv
// Shared types and constants for the minimum covering window search block.
package mwcs_pkg;

  localparam logic [1:0] OP_PATTERN = 2'd0;
  localparam logic [1:0] OP_TEXT    = 2'd1;
  localparam logic [1:0] OP_FINISH  = 2'd2;

  localparam int SYM_W  = 8;
  localparam int DIST_W = 9;
  localparam int START_W = 12;
  localparam int LEN_W   = 13;

  typedef struct packed {
    logic pat_read;
    logic text_write;
    logic finish;
    logic set_overflow;
    logic pat_update;
    logic text_update;
    logic record;
    logic left_read;
    logic left_update;
  } cmd_t;

  typedef struct packed {
    logic pat_locked;
    logic pat_full;
    logic text_full;
    logic covers;
    logic out_busy;
  } status_t;

endpackage

### sv/mwcs_if.sv
// Valid/ready channel interfaces for the input items and the result items.
interface mwcs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] symbol;

  modport source(output valid, output operation, output symbol, input ready);
  modport sink(input valid, input operation, input symbol, output ready);
endinterface

interface mwcs_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [11:0] window_start;
  logic [12:0] window_length;
  logic        overflow;

  modport source(output valid, output found, output window_start, output window_length,
                 output overflow, input ready);
  modport sink(input valid, input found, input window_start, input window_length,
               input overflow, output ready);
endinterface

### sv/mwcs_ctrl.sv
// Sequencer that steps each input item through the count memory and window shrink loop.
module mwcs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_operation,
  output logic              in_ready,
  input  mwcs_pkg::status_t stat,
  output mwcs_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PUPD  = 3'd1;
  localparam logic [2:0] S_TUPD  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_TRD   = 3'd4;
  localparam logic [2:0] S_LUPD  = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       accept;

  assign in_ready = rst_n && (state_r == S_IDLE) &&
                    ((in_operation != mwcs_pkg::OP_FINISH) || !stat.out_busy);
  assign accept = in_valid && in_ready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_operation)
            mwcs_pkg::OP_PATTERN: begin
              if (!stat.pat_locked) begin
                if (stat.pat_full) begin
                  cmd.set_overflow = 1'b1;
                end else begin
                  cmd.pat_read = 1'b1;
                  state_nxt    = S_PUPD;
                end
              end
            end
            mwcs_pkg::OP_TEXT: begin
              if (stat.text_full) begin
                cmd.set_overflow = 1'b1;
              end else begin
                cmd.text_write = 1'b1;
                state_nxt      = S_TUPD;
              end
            end
            mwcs_pkg::OP_FINISH: begin
              cmd.finish = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_PUPD: begin
        cmd.pat_update = 1'b1;
        state_nxt      = S_IDLE;
      end
      S_TUPD: begin
        cmd.text_update = 1'b1;
        state_nxt       = S_CHECK;
      end
      S_CHECK: begin
        if (stat.covers) begin
          cmd.record = 1'b1;
          state_nxt  = S_TRD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_TRD: begin
        cmd.left_read = 1'b1;
        state_nxt     = S_LUPD;
      end
      S_LUPD: begin
        cmd.left_update = 1'b1;
        state_nxt       = S_CHECK;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### sv/mwcs_datapath.sv
// Count memory, text memory, window bounds, best window and result register.
module mwcs_datapath #(
  parameter int TEXT_MAX    = 4096,
  parameter int PATTERN_MAX = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [mwcs_pkg::SYM_W-1:0]     in_symbol,
  input  mwcs_pkg::cmd_t                 cmd,
  output mwcs_pkg::status_t              stat,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_found,
  output logic [mwcs_pkg::START_W-1:0]   out_window_start,
  output logic [mwcs_pkg::LEN_W-1:0]     out_window_length,
  output logic                           out_overflow
);

  localparam int POS_W  = $clog2(TEXT_MAX + 2);
  localparam int ADDR_W = $clog2(TEXT_MAX);
  localparam int PLEN_W = $clog2(PATTERN_MAX + 1);
  localparam int CNT_W  = $clog2(TEXT_MAX + PATTERN_MAX + 1) + 1;
  localparam int ENT_W  = CNT_W + 1;
  localparam int SYMS   = 1 << mwcs_pkg::SYM_W;
  localparam int SW     = mwcs_pkg::START_W;
  localparam int LW     = mwcs_pkg::LEN_W;
  localparam int DW     = mwcs_pkg::DIST_W;

  // Each count entry holds the pattern membership bit above a signed need count.
  logic [ENT_W-1:0]              need_mem [SYMS];
  logic [SYMS-1:0]               need_vld_r;
  logic [SYMS-1:0]               need_vld_nxt;
  logic [ENT_W-1:0]              need_rd_r;
  logic                          need_rd_vld_r;
  logic [mwcs_pkg::SYM_W-1:0]    need_addr_r;
  logic [mwcs_pkg::SYM_W-1:0]    need_raddr;
  logic                          need_re;
  logic                          need_we;
  logic [ENT_W-1:0]              need_wdata;

  logic [mwcs_pkg::SYM_W-1:0]    text_mem [TEXT_MAX];
  logic [mwcs_pkg::SYM_W-1:0]    text_rd_r;

  logic                          ent_pat;
  logic signed [CNT_W-1:0]       ent_cnt;
  logic signed [CNT_W-1:0]       cnt_inc;
  logic signed [CNT_W-1:0]       cnt_dec;

  logic [DW-1:0]                 dn_r, dn_nxt;
  logic [DW-1:0]                 sat_r, sat_nxt;
  logic [POS_W-1:0]              left_r, left_nxt;
  logic [POS_W-1:0]              right_r, right_nxt;
  logic [POS_W-1:0]              best_len_r, best_len_nxt;
  logic [POS_W-1:0]              best_start_r, best_start_nxt;
  logic [PLEN_W-1:0]             plen_r, plen_nxt;
  logic                          ovf_r, ovf_nxt;
  logic [POS_W-1:0]              win_len;

  logic                          out_valid_r, out_valid_nxt;
  logic                          out_found_r;
  logic [SW-1:0]                 out_start_r;
  logic [LW-1:0]                 out_len_r;
  logic                          out_ovf_r;
  logic                          found;
  logic [POS_W+SW-1:0]           start_ext;
  logic [POS_W+LW-1:0]           len_ext;

  assign need_raddr = cmd.left_read ? text_rd_r : in_symbol;
  assign need_re    = cmd.pat_read || cmd.text_write || cmd.left_read;

  assign ent_pat = need_rd_vld_r && need_rd_r[CNT_W];
  assign ent_cnt = need_rd_vld_r ? signed'(need_rd_r[CNT_W-1:0]) : '0;
  assign cnt_inc = ent_cnt + CNT_W'(1);
  assign cnt_dec = ent_cnt - CNT_W'(1);

  always_comb begin
    need_we    = 1'b0;
    need_wdata = {1'b1, cnt_inc};
    if (cmd.pat_update) begin
      need_we = 1'b1;
    end else if (cmd.text_update) begin
      need_we    = ent_pat;
      need_wdata = {1'b1, cnt_dec};
    end else if (cmd.left_update) begin
      need_we = ent_pat;
    end
  end

  assign win_len = right_r - left_r;

  assign stat.pat_locked = (right_r != '0);
  assign stat.pat_full   = (plen_r >= PLEN_W'(PATTERN_MAX));
  assign stat.text_full  = (right_r >= POS_W'(TEXT_MAX));
  assign stat.covers     = (dn_r != '0) && (sat_r == dn_r) && (left_r < right_r);
  assign stat.out_busy   = out_valid_r && !out_ready;

  assign found     = (best_len_r <= POS_W'(TEXT_MAX));
  assign start_ext = {{SW{1'b0}}, best_start_r};
  assign len_ext   = {{LW{1'b0}}, best_len_r};

  always_comb begin
    need_vld_nxt   = need_vld_r;
    dn_nxt         = dn_r;
    sat_nxt        = sat_r;
    left_nxt       = left_r;
    right_nxt      = right_r;
    best_len_nxt   = best_len_r;
    best_start_nxt = best_start_r;
    plen_nxt       = plen_r;
    ovf_nxt        = ovf_r;
    out_valid_nxt  = out_valid_r && !out_ready;

    if (need_we) begin
      need_vld_nxt[need_addr_r] = 1'b1;
    end
    if (cmd.set_overflow) begin
      ovf_nxt = 1'b1;
    end
    if (cmd.text_write) begin
      right_nxt = right_r + POS_W'(1);
    end
    if (cmd.pat_update) begin
      if (!ent_pat) begin
        dn_nxt = dn_r + DW'(1);
      end
      plen_nxt = plen_r + PLEN_W'(1);
    end
    if (cmd.text_update && ent_pat && (cnt_dec == '0)) begin
      sat_nxt = sat_r + DW'(1);
    end
    if (cmd.record && (win_len < best_len_r)) begin
      best_len_nxt   = win_len;
      best_start_nxt = left_r;
    end
    if (cmd.left_update) begin
      if (ent_pat && (ent_cnt == '0)) begin
        sat_nxt = sat_r - DW'(1);
      end
      left_nxt = left_r + POS_W'(1);
    end
    if (cmd.finish) begin
      out_valid_nxt  = 1'b1;
      need_vld_nxt   = '0;
      dn_nxt         = '0;
      sat_nxt        = '0;
      left_nxt       = '0;
      right_nxt      = '0;
      best_len_nxt   = POS_W'(TEXT_MAX + 1);
      best_start_nxt = '0;
      plen_nxt       = '0;
      ovf_nxt        = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      need_vld_r   <= '0;
      dn_r         <= '0;
      sat_r        <= '0;
      left_r       <= '0;
      right_r      <= '0;
      best_len_r   <= POS_W'(TEXT_MAX + 1);
      best_start_r <= '0;
      plen_r       <= '0;
      ovf_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      need_vld_r   <= need_vld_nxt;
      dn_r         <= dn_nxt;
      sat_r        <= sat_nxt;
      left_r       <= left_nxt;
      right_r      <= right_nxt;
      best_len_r   <= best_len_nxt;
      best_start_r <= best_start_nxt;
      plen_r       <= plen_nxt;
      ovf_r        <= ovf_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (need_we) begin
      need_mem[need_addr_r] <= need_wdata;
    end
    if (need_re) begin
      need_rd_r     <= need_mem[need_raddr];
      need_rd_vld_r <= need_vld_r[need_raddr];
      need_addr_r   <= need_raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.text_write) begin
      text_mem[right_r[ADDR_W-1:0]] <= in_symbol;
    end
    if (cmd.record) begin
      text_rd_r <= text_mem[left_r[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_found_r <= found;
      out_start_r <= found ? start_ext[SW-1:0] : '0;
      out_len_r   <= found ? len_ext[LW-1:0] : '0;
      out_ovf_r   <= ovf_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_window_start  = out_start_r;
  assign out_window_length = out_len_r;
  assign out_overflow      = out_ovf_r;

endmodule

### sv/min_window_cover_search.sv
// Top level of the minimum covering window search block.
// The input channel takes items of an operation and a byte: pattern bytes first,
// then text bytes, then a finish item. Only a finish item yields a transfer on the
// result channel, carrying found, window start, window length and overflow.
// A pattern byte passes through the pattern update state; a text byte passes through
// the text update and check states, plus a read and a left update state for each
// byte that leaves the window on the left. No new item is taken until idle again. The
// read, update and write back of the 256-entry count memory, one access at a time,
// sets this sequence. Bytes refused at a size limit and unused operations stay in idle.
// The result appears on the result channel the cycle after the finish transfer;
// the finish also returns all state to its start values for the next job.
// A held result does not stop pattern or text bytes; only a further finish
// waits until the result has been taken.
// Reset clears all control state and marks every count entry empty at once,
// so the block takes items in the first cycle after reset is released.
module min_window_cover_search #(
  parameter int TEXT_MAX    = 4096,
  parameter int PATTERN_MAX = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  mwcs_in_if.sink    in_ch,
  mwcs_out_if.source out_ch
);

  mwcs_pkg::cmd_t    cmd;
  mwcs_pkg::status_t stat;

  mwcs_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_operation (in_ch.operation),
    .in_ready     (in_ch.ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  mwcs_datapath #(
    .TEXT_MAX    (TEXT_MAX),
    .PATTERN_MAX (PATTERN_MAX)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_symbol         (in_ch.symbol),
    .cmd               (cmd),
    .stat              (stat),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_found         (out_ch.found),
    .out_window_start  (out_ch.window_start),
    .out_window_length (out_ch.window_length),
    .out_overflow      (out_ch.overflow)
  );

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("More than one datapath command is active.");

  a_finish_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && (in_ch.operation == mwcs_pkg::OP_FINISH))
      |=> out_ch.valid)
    else $error("A finish transfer did not produce a result.");

  a_left_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.left_update |-> $past(cmd.left_read))
    else $error("A left count update was not preceded by its read.");

  a_record_covers: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.record |-> (stat.covers && !in_ch.ready))
    else $error("A window was recorded while it does not cover the pattern.");

endmodule

### bench/min_window_cover_search_tb.sv
// Self-checking testbench for the minimum covering window search block.
module min_window_cover_search_tb;

  localparam int TXT_MAX = 4096;
  localparam int PAT_MAX = 256;
  localparam int IDLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 100;
  localparam int ITEMS_PER_PHASE = 190;
  localparam int LONG_TEXT = 300;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]                   op;
    logic [mwcs_pkg::SYM_W-1:0]   sym;
  } stream_item_t;

  typedef struct packed {
    logic                         found;
    logic [mwcs_pkg::START_W-1:0] start;
    logic [mwcs_pkg::LEN_W-1:0]   length;
    logic                         overflow;
  } cover_result_t;

  logic clk;
  logic rst_n;

  mwcs_in_if  in_ch();
  mwcs_out_if out_ch();

  min_window_cover_search #(
    .TEXT_MAX(TXT_MAX),
    .PATTERN_MAX(PAT_MAX)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  stream_item_t  tx_items[$];
  cover_result_t expected_covers[$];
  stream_item_t  item_on_bus;
  cover_result_t got_cover;
  cover_result_t want_cover;
  int            send_idle_pct;
  int            recv_stall_pct;
  int            mismatch_count;
  int            quiet_cycles;
  int            stim_count;

  // Predictor state for the current job.
  int                         need_left[256];
  bit                         in_pat[256];
  logic [mwcs_pkg::SYM_W-1:0] text_mem[TXT_MAX];
  int                         distinct_cnt;
  int                         met_cnt;
  int                         win_lo;
  int                         win_hi;
  int                         shortest_len;
  int                         shortest_pos;
  int                         pat_cnt;
  bit                         ovf_seen;

  function automatic void clear_cover_state();
    for (int i = 0; i < 256; i++) begin
      need_left[i] = 0;
      in_pat[i] = 1'b0;
    end
    distinct_cnt = 0;
    met_cnt = 0;
    win_lo = 0;
    win_hi = 0;
    shortest_len = TXT_MAX + 1;
    shortest_pos = 0;
    pat_cnt = 0;
    ovf_seen = 1'b0;
  endfunction

  function automatic void cover_model_step(stream_item_t it);
    cover_result_t res;
    int c;
    int d;
    c = it.sym;
    case (it.op)
      mwcs_pkg::OP_PATTERN: begin
        if (win_hi == 0) begin
          if (pat_cnt >= PAT_MAX) begin
            ovf_seen = 1'b1;
          end else begin
            if (!in_pat[c]) begin
              in_pat[c] = 1'b1;
              distinct_cnt++;
            end
            need_left[c]++;
            pat_cnt++;
          end
        end
      end
      mwcs_pkg::OP_TEXT: begin
        if (win_hi >= TXT_MAX) begin
          ovf_seen = 1'b1;
        end else begin
          text_mem[win_hi] = it.sym;
          win_hi++;
          if (in_pat[c]) begin
            need_left[c]--;
            if (need_left[c] == 0) met_cnt++;
          end
          while (distinct_cnt != 0 && met_cnt == distinct_cnt && win_lo < win_hi) begin
            if (win_hi - win_lo < shortest_len) begin
              shortest_len = win_hi - win_lo;
              shortest_pos = win_lo;
            end
            d = text_mem[win_lo];
            if (in_pat[d]) begin
              if (need_left[d] == 0) met_cnt--;
              need_left[d]++;
            end
            win_lo++;
          end
        end
      end
      mwcs_pkg::OP_FINISH: begin
        res.found = (shortest_len <= TXT_MAX);
        res.start = res.found ? shortest_pos[mwcs_pkg::START_W-1:0] : '0;
        res.length = res.found ? shortest_len[mwcs_pkg::LEN_W-1:0] : '0;
        res.overflow = ovf_seen;
        expected_covers.push_back(res);
        clear_cover_state();
      end
      default: begin
      end
    endcase
  endfunction

  function automatic logic [mwcs_pkg::SYM_W-1:0] rand_sym();
    int unsigned r;
    r = $urandom_range(255);
    return r[mwcs_pkg::SYM_W-1:0];
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Driver: presents queued items, inserting idle cycles at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) cover_model_step(item_on_bus);
      if (!in_ch.valid || in_ch.ready) begin
        if (tx_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          item_on_bus = tx_items.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.operation <= item_on_bus.op;
          in_ch.symbol <= item_on_bus.sym;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transfer against the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got_cover.found = out_ch.found;
        got_cover.start = out_ch.window_start;
        got_cover.length = out_ch.window_length;
        got_cover.overflow = out_ch.overflow;
        if (expected_covers.size() == 0) begin
          $error("result transfer with no result expected");
          mismatch_count++;
        end else begin
          want_cover = expected_covers.pop_front();
          if (got_cover.found !== want_cover.found) begin
            $error("found: expected %0d, actual %0d", want_cover.found, got_cover.found);
            mismatch_count++;
          end
          if (got_cover.start !== want_cover.start) begin
            $error("window_start: expected %0d, actual %0d", want_cover.start,
                   got_cover.start);
            mismatch_count++;
          end
          if (got_cover.length !== want_cover.length) begin
            $error("window_length: expected %0d, actual %0d", want_cover.length,
                   got_cover.length);
            mismatch_count++;
          end
          if (got_cover.overflow !== want_cover.overflow) begin
            $error("overflow: expected %0d, actual %0d", want_cover.overflow,
                   got_cover.overflow);
            mismatch_count++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic queue_item(logic [1:0] op, logic [mwcs_pkg::SYM_W-1:0] sym);
    tx_items.push_back(stream_item_t'{op: op, sym: sym});
    if (op != OP_UNUSED) stim_count++;
  endtask

  task automatic wait_all_done();
    while (tx_items.size() != 0 || in_ch.valid || expected_covers.size() != 0)
      @(negedge clk);
  endtask

  task automatic queue_directed();
    queue_item(mwcs_pkg::OP_FINISH, 8'hFF);
    queue_item(mwcs_pkg::OP_PATTERN, 8'h00);
    queue_item(mwcs_pkg::OP_PATTERN, 8'hFF);
    queue_item(mwcs_pkg::OP_TEXT, 8'hFF);
    queue_item(mwcs_pkg::OP_TEXT, 8'h12);
    queue_item(mwcs_pkg::OP_TEXT, 8'h00);
    queue_item(mwcs_pkg::OP_FINISH, 8'h00);
    // A pattern byte after text and an unused operation are both dropped.
    queue_item(mwcs_pkg::OP_PATTERN, 8'h55);
    queue_item(mwcs_pkg::OP_TEXT, 8'h55);
    queue_item(mwcs_pkg::OP_PATTERN, 8'hAA);
    queue_item(OP_UNUSED, 8'hAA);
    queue_item(mwcs_pkg::OP_TEXT, 8'h01);
    queue_item(mwcs_pkg::OP_FINISH, 8'h00);
    queue_item(mwcs_pkg::OP_PATTERN, 8'h80);
    queue_item(mwcs_pkg::OP_PATTERN, 8'h80);
    queue_item(mwcs_pkg::OP_TEXT, 8'h80);
    queue_item(mwcs_pkg::OP_TEXT, 8'h7F);
    queue_item(mwcs_pkg::OP_FINISH, 8'h7F);
    queue_item(mwcs_pkg::OP_PATTERN, 8'h01);
    queue_item(mwcs_pkg::OP_TEXT, 8'h02);
    queue_item(mwcs_pkg::OP_TEXT, 8'h01);
    queue_item(mwcs_pkg::OP_TEXT, 8'h03);
    queue_item(mwcs_pkg::OP_TEXT, 8'h01);
    queue_item(mwcs_pkg::OP_FINISH, 8'h01);
  endtask

  // One job whose shortest covering window spans a long run of text.
  task automatic queue_long_window_job();
    logic [mwcs_pkg::SYM_W-1:0] s;
    queue_item(mwcs_pkg::OP_PATTERN, 8'h41);
    queue_item(mwcs_pkg::OP_PATTERN, 8'h42);
    queue_item(mwcs_pkg::OP_TEXT, 8'h41);
    for (int i = 0; i < LONG_TEXT - 2; i++) begin
      do s = rand_sym(); while (s == 8'h41 || s == 8'h42);
      queue_item(mwcs_pkg::OP_TEXT, s);
    end
    queue_item(mwcs_pkg::OP_TEXT, 8'h42);
    for (int i = 0; i < 3; i++) queue_item(mwcs_pkg::OP_TEXT, 8'h42);
    queue_item(mwcs_pkg::OP_FINISH, rand_sym());
  endtask

  // Pattern longer than the limit, then a text that covers the kept part.
  task automatic queue_long_pattern_job();
    for (int i = 0; i < PAT_MAX + 4; i++) queue_item(mwcs_pkg::OP_PATTERN, 8'h3C);
    for (int i = 0; i < PAT_MAX + 3; i++) queue_item(mwcs_pkg::OP_TEXT, 8'h3C);
    queue_item(mwcs_pkg::OP_FINISH, 8'h3C);
  endtask

  task automatic queue_random_job();
    logic [mwcs_pkg::SYM_W-1:0] alpha[4];
    int plen;
    int tlen;
    for (int i = 0; i < 4; i++) alpha[i] = rand_sym();
    plen = ($urandom_range(11) == 0) ? 0 : $urandom_range(1, 5);
    tlen = $urandom_range(0, 40);
    for (int i = 0; i < plen; i++) queue_item(mwcs_pkg::OP_PATTERN, alpha[$urandom_range(3)]);
    for (int i = 0; i < tlen; i++) begin
      if ($urandom_range(99) < 3) queue_item(OP_UNUSED, rand_sym());
      if ($urandom_range(99) < 3) queue_item(mwcs_pkg::OP_PATTERN, rand_sym());
      if ($urandom_range(99) < 80) queue_item(mwcs_pkg::OP_TEXT, alpha[$urandom_range(3)]);
      else queue_item(mwcs_pkg::OP_TEXT, rand_sym());
    end
    queue_item(mwcs_pkg::OP_FINISH, rand_sym());
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.operation = mwcs_pkg::OP_PATTERN;
    in_ch.symbol = '0;
    out_ch.ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    mismatch_count = 0;
    quiet_cycles = 0;
    stim_count = 0;
    clear_cover_state();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      stim_count = 0;
      if (ph == 0) queue_directed();
      if (ph == 1) queue_long_window_job();
      if (ph == 2) queue_long_pattern_job();
      stim_count = 0;
      while (stim_count < ITEMS_PER_PHASE) queue_random_job();
      // The sender holds off here until every predicted result has arrived.
      wait_all_done();
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && expected_covers.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
sv/mwcs_pkg.sv
sv/mwcs_if.sv
sv/mwcs_ctrl.sv
sv/mwcs_datapath.sv
sv/min_window_cover_search.sv
bench/min_window_cover_search_tb.sv
